@@ sv/bbmh_pkg.sv @@
`default_nettype none

package bbmh_pkg;

    localparam int DEF_CAPACITY    = 16;
    localparam int DEF_VALUE_WIDTH = 32;

    // Widths of the payload fields on the ports.
    localparam int FIELD_W     = 32;
    localparam int COUNT_OUT_W = 5;

    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_PEEK  = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]                operation;
        logic signed [FIELD_W-1:0] push_value;
    } t_heap_in;

    typedef struct packed {
        logic [1:0]                status;
        logic signed [FIELD_W-1:0] top_value;
        logic [COUNT_OUT_W-1:0]    entry_count;
        logic                      is_empty;
    } t_heap_out;

endpackage

`default_nettype wire

@@ sv/bbmh_ram.sv @@
`default_nettype none

module bbmh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ sv/bbmh_cmp.sv @@
`default_nettype none

module bbmh_cmp #(
    parameter int WIDTH = 32
) (
    input  wire logic [WIDTH-1:0] i_a,
    input  wire logic [WIDTH-1:0] i_b,
    output logic                  o_lt
);

    // Two's complement ordering of the stored values.
    assign o_lt = $signed(i_a) < $signed(i_b);

endmodule

`default_nettype wire

@@ sv/bounded_binary_min_heap.sv @@
`default_nettype none

// Bounded binary min-heap of signed values, CAPACITY entries of VALUE_WIDTH bits held in one
// single-port-write, registered-read RAM. Each input beat asks for push, pop, peek or clear and
// gives exactly one result beat carrying a status, the minimum for pop or peek, and the count.
// One item is worked on at a time and o_in_ready is low until its result has been loaded into
// the output register. Every step goes through one RAM read and one shared signed comparator:
// a push lets the new value climb past each larger parent, a pop reads the root, moves the
// last entry to the root and lets it sink past each smaller child, and a peek reads the root.
// The result register lets the next item be accepted while a finished result still waits
// to be taken.
module bounded_binary_min_heap
    import bbmh_pkg::*;
#(
    parameter int CAPACITY    = DEF_CAPACITY,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_heap_in  i_in,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_heap_out      o_out
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = AW + 2;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_UP       = 4'd1;
    localparam logic [3:0] S_UP_W     = 4'd2;
    localparam logic [3:0] S_PEEK     = 4'd3;
    localparam logic [3:0] S_POP_ROOT = 4'd4;
    localparam logic [3:0] S_POP_LAST = 4'd5;
    localparam logic [3:0] S_DN       = 4'd6;
    localparam logic [3:0] S_DN_L     = 4'd7;
    localparam logic [3:0] S_DN_R     = 4'd8;
    localparam logic [3:0] S_DN_D     = 4'd9;
    localparam logic [3:0] S_RES      = 4'd10;

    logic [3:0]             r_state,     n_state;
    logic [CW-1:0]          r_count,     n_count;
    logic [AW-1:0]          r_pos,       n_pos;
    logic [AW-1:0]          r_cidx,      n_cidx;
    logic [VALUE_WIDTH-1:0] r_val,       n_val;
    logic [VALUE_WIDTH-1:0] r_child,     n_child;
    logic [VALUE_WIDTH-1:0] r_top,       n_top;
    logic [1:0]             r_status,    n_status;
    logic                   r_out_valid, n_out_valid;
    t_heap_out              r_out,       n_out;

    logic                   w_we;
    logic [AW-1:0]          w_raddr;
    logic [VALUE_WIDTH-1:0] w_wdata;
    logic [VALUE_WIDTH-1:0] w_rdata;
    logic [VALUE_WIDTH-1:0] w_cmp_a;
    logic [VALUE_WIDTH-1:0] w_cmp_b;
    logic                   w_lt;

    logic [VALUE_WIDTH-1:0] w_push;
    logic [FIELD_W-1:0]     w_top_out;
    logic [COUNT_OUT_W-1:0] w_cnt_out;
    logic [AW-1:0]          w_parent;
    logic [XW-1:0]          w_left;
    logic [XW-1:0]          w_right;
    logic [XW-1:0]          w_cnt_x;
    logic                   w_accept;

    // Incoming values are cut to VALUE_WIDTH bits or sign-extended; results keep their low bits, zero-extended.
    generate
        if (VALUE_WIDTH <= FIELD_W) begin : g_in_narrow
            assign w_push = i_in.push_value[VALUE_WIDTH-1:0];
        end else begin : g_in_wide
            assign w_push = {{(VALUE_WIDTH - FIELD_W){i_in.push_value[FIELD_W-1]}},
                             i_in.push_value};
        end
        if (VALUE_WIDTH >= FIELD_W) begin : g_out_wide
            assign w_top_out = r_top[FIELD_W-1:0];
        end else begin : g_out_narrow
            assign w_top_out = {{(FIELD_W - VALUE_WIDTH){1'b0}}, r_top};
        end
        if (CW >= COUNT_OUT_W) begin : g_cnt_wide
            assign w_cnt_out = r_count[COUNT_OUT_W-1:0];
        end else begin : g_cnt_narrow
            assign w_cnt_out = {{(COUNT_OUT_W - CW){1'b0}}, r_count};
        end
    endgenerate

    assign w_parent = (r_pos - AW'(1)) >> 1;
    assign w_left   = {1'b0, r_pos, 1'b1};
    assign w_right  = {1'b0, r_pos, 1'b0} + XW'(2);
    assign w_cnt_x  = XW'(r_count);

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    bbmh_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_pos),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    bbmh_cmp #(
        .WIDTH (VALUE_WIDTH)
    ) u_cmp (
        .i_a  (w_cmp_a),
        .i_b  (w_cmp_b),
        .o_lt (w_lt)
    );

    always_comb begin
        unique case (r_state)
            S_DN_R: begin
                w_cmp_a = w_rdata;
                w_cmp_b = r_child;
            end
            S_DN_D: begin
                w_cmp_a = r_child;
                w_cmp_b = r_val;
            end
            default: begin
                w_cmp_a = r_val;
                w_cmp_b = w_rdata;
            end
        endcase
    end

    // The moving entry stays in r_val and only the hole at r_pos is written, which leaves the
    // RAM as a chain of swaps would.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pos       = r_pos;
        n_cidx      = r_cidx;
        n_val       = r_val;
        n_child     = r_child;
        n_top       = r_top;
        n_status    = r_status;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        w_we        = 1'b0;
        w_wdata     = r_val;
        w_raddr     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_top    = '0;
                    n_status = ST_OK;
                    unique case (i_in.operation)
                        OP_PUSH: begin
                            if (r_count == CW'(CAPACITY)) begin
                                n_status = ST_FULL;
                                n_state  = S_RES;
                            end else begin
                                n_val   = w_push;
                                n_pos   = AW'(r_count);
                                n_count = r_count + CW'(1);
                                n_state = S_UP;
                            end
                        end
                        OP_POP: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_RES;
                            end else begin
                                n_state = S_POP_ROOT;
                            end
                        end
                        OP_PEEK: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_RES;
                            end else begin
                                n_state = S_PEEK;
                            end
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                            n_state = S_RES;
                        end
                    endcase
                end
            end
            S_UP: begin
                if (r_pos == '0) begin
                    w_we    = 1'b1;
                    n_state = S_RES;
                end else begin
                    w_raddr = w_parent;
                    n_state = S_UP_W;
                end
            end
            S_UP_W: begin
                w_we = 1'b1;
                if (w_lt) begin
                    w_wdata = w_rdata;
                    n_pos   = w_parent;
                    n_state = S_UP;
                end else begin
                    n_state = S_RES;
                end
            end
            S_PEEK: begin
                n_top   = w_rdata;
                n_state = S_RES;
            end
            S_POP_ROOT: begin
                n_top   = w_rdata;
                n_count = r_count - CW'(1);
                if (r_count == CW'(1)) begin
                    n_state = S_RES;
                end else begin
                    w_raddr = AW'(r_count - CW'(1));
                    n_state = S_POP_LAST;
                end
            end
            S_POP_LAST: begin
                n_val   = w_rdata;
                n_pos   = '0;
                n_state = S_DN;
            end
            S_DN: begin
                if (w_left >= w_cnt_x) begin
                    w_we    = 1'b1;
                    n_state = S_RES;
                end else begin
                    w_raddr = w_left[AW-1:0];
                    n_state = S_DN_L;
                end
            end
            S_DN_L: begin
                n_child = w_rdata;
                n_cidx  = w_left[AW-1:0];
                if (w_right < w_cnt_x) begin
                    w_raddr = w_right[AW-1:0];
                    n_state = S_DN_R;
                end else begin
                    n_state = S_DN_D;
                end
            end
            S_DN_R: begin
                // The right child wins only when strictly smaller.
                if (w_lt) begin
                    n_child = w_rdata;
                    n_cidx  = w_right[AW-1:0];
                end
                n_state = S_DN_D;
            end
            S_DN_D: begin
                w_we = 1'b1;
                if (w_lt) begin
                    w_wdata = r_child;
                    n_pos   = r_cidx;
                    n_state = S_DN;
                end else begin
                    n_state = S_RES;
                end
            end
            S_RES: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.status      = r_status;
                    n_out.top_value   = w_top_out;
                    n_out.entry_count = w_cnt_out;
                    n_out.is_empty    = (r_count == '0);
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_pos    <= n_pos;
        r_cidx   <= n_cidx;
        r_val    <= n_val;
        r_child  <= n_child;
        r_top    <= n_top;
        r_status <= n_status;
        r_out    <= n_out;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.operation == OP_PUSH && r_count != CW'(CAPACITY))
        |=> r_count == $past(r_count) + CW'(1))
        else $error("accepted push did not add an entry");

    a_write_in_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> XW'(r_pos) < w_cnt_x)
        else $error("store written beyond the last entry");

    a_fail_no_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status != ST_OK) |-> o_out.top_value == '0)
        else $error("failed operation returned a value");
`endif

endmodule

`default_nettype wire
